/* sv/itfw_pkg.sv */
// shared types, constants and the binary to bcd step for the decimal text formatter
package itfw_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAG_W          = 64;
    localparam int BCD_DIGITS     = 20;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int BITS_PER_STAGE = 8;
    localparam int DD_STAGES      = MAG_W / BITS_PER_STAGE;
    localparam int ND_W           = $clog2(BCD_DIGITS + 1);
    localparam int FW_W           = 6;
    localparam int CHAR_W         = 8;
    localparam int POS_W          = 5;
    localparam int CFG_IDX_W      = 1;

    localparam logic [FW_W-1:0]   FW_RESET   = 6'd20;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_WIDTH = 1'b0,
        CFG_FILL_CHAR   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [FW_W-1:0]   field_width;
        logic [CHAR_W-1:0] fill_char;
    } cfg_t;

    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  bin;
        logic [BCD_W-1:0]  bcd;
    } dd_t;

    // one shift-and-add-3 iteration over all bcd digits
    function automatic dd_t dabble_step(dd_t d);
        dd_t        r;
        logic [3:0] dig;
        r = d;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            dig = r.bcd[k*4 +: 4];
            if (dig >= 4'd5) begin
                r.bcd[k*4 +: 4] = dig + 4'd3;
            end
        end
        r.bcd = {r.bcd[BCD_W-2:0], r.bin[MAG_W-1]};
        r.bin = {r.bin[MAG_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

/* sv/itfw_abs.sv */
// input stage: sign and magnitude of the incoming value
module itfw_abs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [itfw_pkg::MAG_W-1:0] in_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output itfw_pkg::dd_t                   out_data
);

    logic          valid_reg;
    itfw_pkg::dd_t data_reg;
    itfw_pkg::dd_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.neg = in_value[itfw_pkg::MAG_W-1];
        data_next.bin = in_value[itfw_pkg::MAG_W-1] ?
                        (~in_value + itfw_pkg::MAG_W'(1)) : in_value;
        data_next.bcd = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/itfw_dabble_stage.sv */
// one pipeline stage of the binary to bcd conversion
module itfw_dabble_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  itfw_pkg::dd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output itfw_pkg::dd_t out_data
);

    logic          valid_reg;
    itfw_pkg::dd_t data_reg;
    itfw_pkg::dd_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = in_data;
        for (int s = 0; s < itfw_pkg::BITS_PER_STAGE; s++) begin
            data_next = itfw_pkg::dabble_step(data_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* sv/itfw_emit.sv */
// character sequencer: holds one converted value and emits the field left to right
module itfw_emit #(
    parameter int MAX_WIDTH = itfw_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  itfw_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  itfw_pkg::dd_t                 in_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itfw_pkg::POS_W-1:0]    m_position,
    output logic [itfw_pkg::CHAR_W-1:0]   m_out_char,
    output logic                          m_last
);

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic                                          busy_reg;
    logic [CW-1:0]                                 idx_reg;
    logic [itfw_pkg::BCD_DIGITS-1:0][3:0]          digits_reg;
    logic                                          neg_reg;
    logic [itfw_pkg::ND_W-1:0]                     nd_reg;
    logic                                          m_valid_reg;
    logic [itfw_pkg::POS_W-1:0]                    m_position_reg;
    logic [itfw_pkg::CHAR_W-1:0]                   m_out_char_reg;
    logic                                          m_last_reg;

    logic [CW-1:0]               n;
    logic [CW-1:0]               r;
    logic [4:0]                  ridx;
    logic [itfw_pkg::ND_W-1:0]   nd_next;
    logic                        emit;
    logic                        last_char;
    logic                        load;
    logic [itfw_pkg::CHAR_W-1:0] sign_char;
    logic [itfw_pkg::CHAR_W-1:0] char_next;

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last     = m_last_reg;

    always_comb begin
        if ({1'b0, cfg.field_width} > 7'(MAX_WIDTH)) begin
            n = CW'(MAX_WIDTH);
        end else begin
            n = CW'(cfg.field_width);
        end
    end

    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign last_char = (idx_reg == n - CW'(1));
    assign in_ready  = !busy_reg || (emit && last_char);
    assign load      = in_valid && in_ready;

    assign r         = n - CW'(1) - idx_reg;
    assign ridx      = r[4:0];
    assign sign_char = neg_reg ? itfw_pkg::MINUS_CODE : cfg.fill_char;

    always_comb begin
        if (r < CW'(nd_reg)) begin
            char_next = itfw_pkg::DIGIT_ZERO + {4'b0000, digits_reg[ridx]};
        end else if (cfg.fill_char == itfw_pkg::SPACE_CODE) begin
            char_next = (r == CW'(nd_reg)) ? sign_char : itfw_pkg::SPACE_CODE;
        end else if (idx_reg == '0) begin
            char_next = sign_char;
        end else begin
            char_next = cfg.fill_char;
        end
    end

    // count of significant digits
    always_comb begin
        nd_next = '0;
        for (int k = 0; k < itfw_pkg::BCD_DIGITS; k++) begin
            if (in_data.bcd[k*4 +: 4] != 4'd0) begin
                nd_next = itfw_pkg::ND_W'(k + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= (n != '0);
                idx_reg  <= '0;
            end else if (emit) begin
                idx_reg <= idx_reg + CW'(1);
                if (last_char) begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_position_reg <= idx_reg[itfw_pkg::POS_W-1:0];
            m_out_char_reg <= char_next;
            m_last_reg     <= last_char;
        end
        if (load) begin
            digits_reg <= in_data.bcd;
            neg_reg    <= in_data.neg;
            nd_reg     <= nd_next;
        end
    end

endmodule

/* sv/int_to_fixed_width_decimal_text.sv */
// top level of the fixed-width decimal text formatter
// Formats a signed 64-bit value as a right-aligned decimal field of field_width characters
// (capped at MAX_WIDTH), one character per m_ transaction from position 0 to the rightmost,
// which carries m_last. Characters leave one per cycle through the single output register
// while m_ready stays high; with a field width of zero a value is absorbed and gives no
// transaction. The front end is a ten-stage pipeline (magnitude, eight binary to bcd stages
// of eight bits each, a holding stage) that accepts a value every cycle while it has room.
// A fill_char of space puts the sign next to the digits; any other fill puts the sign at
// position 0. The user must write configuration through cfg_wr_en, cfg_index and cfg_wdata
// only while no value is in flight; the block itself does not enforce this.
module int_to_fixed_width_decimal_text #(
    parameter int MAX_WIDTH = itfw_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [itfw_pkg::MAG_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [itfw_pkg::POS_W-1:0]          m_position,
    output logic [itfw_pkg::CHAR_W-1:0]         m_out_char,
    output logic                                m_last,
    input  logic                                cfg_wr_en,
    input  logic [itfw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [itfw_pkg::CHAR_W-1:0]         cfg_wdata
);

    itfw_pkg::cfg_t cfg_reg;

    logic          stage_valid [itfw_pkg::DD_STAGES+1];
    logic          stage_ready [itfw_pkg::DD_STAGES+1];
    itfw_pkg::dd_t stage_data  [itfw_pkg::DD_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_width <= itfw_pkg::FW_RESET;
            cfg_reg.fill_char   <= itfw_pkg::SPACE_CODE;
        end else if (cfg_wr_en) begin
            case (itfw_pkg::cfg_reg_t'(cfg_index))
                itfw_pkg::CFG_FIELD_WIDTH: begin
                    cfg_reg.field_width <= cfg_wdata[itfw_pkg::FW_W-1:0];
                end
                itfw_pkg::CFG_FILL_CHAR: begin
                    cfg_reg.fill_char <= cfg_wdata;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    itfw_abs u_abs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar g = 0; g < itfw_pkg::DD_STAGES; g++) begin : g_dabble
        itfw_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    itfw_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (stage_valid[itfw_pkg::DD_STAGES]),
        .in_ready   (stage_ready[itfw_pkg::DD_STAGES]),
        .in_data    (stage_data[itfw_pkg::DD_STAGES]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

/* sv/itfw_checker.sv */
// port-level checks on the result channel of the decimal text formatter, with its bind
module itfw_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [itfw_pkg::POS_W-1:0]  m_position,
    input logic [itfw_pkg::CHAR_W-1:0] m_out_char,
    input logic                        m_last
);

    // a field keeps streaming once started
    a_field_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("field stream broken before last character");

    a_position_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_position == $past(m_position) + 5'd1)
        else $error("position did not advance by one");

    a_field_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || m_position == '0)
        else $error("new field does not start at position zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_position))
        else $error("result transaction changed while stalled");

endmodule

bind int_to_fixed_width_decimal_text itfw_checker u_itfw_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_position (m_position),
    .m_out_char (m_out_char),
    .m_last     (m_last)
);

/* tb/sv/int_to_fixed_width_decimal_text_test.sv */
// testbench for int_to_fixed_width_decimal_text: directed and random values checked per character
`timescale 1ns / 100ps

module int_to_fixed_width_decimal_text_test;

    localparam int                         FIELD_MAX     = itfw_pkg::MAX_WIDTH_DEF;
    localparam int                         SETTLE_CYCLES = 40;
    localparam int                         ITEMS_PER_CFG = 27;
    localparam logic [itfw_pkg::CHAR_W-1:0] STAR_CODE    = 8'h2A;
    localparam logic [63:0]                INT64_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0]                INT64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [itfw_pkg::POS_W-1:0]  position;
        logic [itfw_pkg::CHAR_W-1:0] out_char;
        logic                        last;
    } text_char_t;

    logic                               aclk       = 1'b0;
    logic                               aresetn    = 1'b0;
    logic                               s_valid    = 1'b0;
    logic                               s_ready;
    logic signed [itfw_pkg::MAG_W-1:0]  s_value    = '0;
    logic                               m_valid;
    logic                               m_ready    = 1'b0;
    logic [itfw_pkg::POS_W-1:0]         m_position;
    logic [itfw_pkg::CHAR_W-1:0]        m_out_char;
    logic                               m_last;
    logic                               cfg_wr_en  = 1'b0;
    logic [itfw_pkg::CFG_IDX_W-1:0]     cfg_index  = '0;
    logic [itfw_pkg::CHAR_W-1:0]        cfg_wdata  = '0;

    logic [itfw_pkg::FW_W-1:0]   cur_width = itfw_pkg::FW_RESET;
    logic [itfw_pkg::CHAR_W-1:0] cur_fill  = itfw_pkg::SPACE_CODE;
    text_char_t                  expected_chars[$];
    int                          errors    = 0;
    int                          idle_pct  = 0;
    int                          stall_pct = 0;

    int_to_fixed_width_decimal_text i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .m_out_char (m_out_char),
        .m_last     (m_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("int_to_fixed_width_decimal_text verification failed");
        $finish;
    end

    // expected text field for one value under the current width and fill
    task automatic format_value_chars(logic [63:0] v);
        logic [itfw_pkg::CHAR_W-1:0] text [FIELD_MAX];
        logic [63:0]                 mag;
        logic [itfw_pkg::CHAR_W-1:0] sign;
        int                          n;
        text_char_t                  c;
        mag  = v[63] ? 64'd0 - v : v;
        sign = v[63] ? itfw_pkg::MINUS_CODE : cur_fill;
        n    = (cur_width > FIELD_MAX) ? FIELD_MAX : int'(cur_width);
        for (int i = n - 1; i >= 0; i--) begin
            if (mag != 64'd0) begin
                text[i] = itfw_pkg::DIGIT_ZERO + itfw_pkg::CHAR_W'(mag % 64'd10);
                mag     = mag / 64'd10;
            end else if (cur_fill == itfw_pkg::SPACE_CODE) begin
                text[i] = sign;
                sign    = cur_fill;
            end else if (i == 0) begin
                text[i] = sign;
            end else begin
                text[i] = cur_fill;
            end
        end
        for (int i = 0; i < n; i++) begin
            c.position = itfw_pkg::POS_W'(i);
            c.out_char = text[i];
            c.last     = (i == n - 1);
            expected_chars.push_back(c);
        end
    endtask

    task automatic send_value(logic [63:0] v);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        forever begin
            @(posedge aclk);
            if (s_valid && s_ready) break;
        end
        format_value_chars(v);
    endtask

    // stop sending and wait for every expected character
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(itfw_pkg::cfg_reg_t idx, logic [itfw_pkg::CHAR_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == itfw_pkg::CFG_FIELD_WIDTH) begin
            cur_width = data[itfw_pkg::FW_W-1:0];
        end else begin
            cur_fill = data;
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_format(logic [itfw_pkg::CHAR_W-1:0] width,
                              logic [itfw_pkg::CHAR_W-1:0] fill);
        drain_results();
        write_reg(itfw_pkg::CFG_FIELD_WIDTH, width);
        write_reg(itfw_pkg::CFG_FILL_CHAR, fill);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        logic [63:0] p10;
        int          d;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(999));
            2: v = {$urandom, $urandom} >> $urandom_range(63);
            3: begin
                p10 = 64'd1;
                d   = $urandom_range(18);
                repeat (d) p10 = p10 * 64'd10;
                v = p10 + 64'($urandom_range(2)) - 64'd1;
            end
            default: begin
                case ($urandom_range(3))
                    0: v = INT64_MIN;
                    1: v = INT64_MAX;
                    2: v = 64'd0;
                    default: v = '1;
                endcase
            end
        endcase
        if ($urandom_range(1) == 1) v = 64'd0 - v;
        return v;
    endfunction

    // reset values: width 20 with space fill
    task automatic test_reset_format();
        send_value(64'd0);
        send_value(64'd1);
        send_value('1);
        send_value(64'd42);
        send_value(-64'sd42);
        send_value(INT64_MAX);
        send_value(INT64_MIN);
        send_value(64'd1000000000000000000);
    endtask

    // sign at position 0 with a non-space fill
    task automatic test_fill_styles();
        set_format(8'd12, STAR_CODE);
        send_value(-64'sd7);
        send_value(64'd7);
        send_value(64'd0);
        send_value(-64'sd1234567890);
        set_format(8'd32, 8'h00);
        send_value(-64'sd5);
        set_format(8'd6, 8'hFF);
        send_value(64'd31);
    endtask

    // digits and sign dropped when the field is too narrow
    task automatic test_narrow_fields();
        set_format(8'd1, itfw_pkg::SPACE_CODE);
        send_value(-64'sd9);
        send_value(64'd5);
        set_format(8'd3, itfw_pkg::DIGIT_ZERO);
        send_value(-64'sd12345);
        send_value(-64'sd12);
        send_value(64'd0);
    endtask

    // zero width gives nothing, widths above the maximum saturate
    task automatic test_width_extremes();
        set_format(8'd0, itfw_pkg::SPACE_CODE);
        send_value(64'd123);
        send_value(INT64_MIN);
        set_format(8'd63, STAR_CODE);
        send_value(INT64_MAX);
        send_value(INT64_MIN);
        set_format(8'd32, itfw_pkg::SPACE_CODE);
        send_value('1);
    endtask

    task automatic test_random_traffic();
        int                          idle_tab  [4] = '{0, 55, 0, 33};
        int                          stall_tab [4] = '{0, 0, 55, 33};
        logic [itfw_pkg::CHAR_W-1:0] width;
        logic [itfw_pkg::CHAR_W-1:0] fill;
        for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 4; c++) begin
                if (p == 0) begin
                    width = (c == 0) ? 8'd1 : (c == 1) ? 8'd32 : (c == 2) ? 8'd63 : 8'd20;
                    fill  = (c == 0) ? itfw_pkg::DIGIT_ZERO :
                            (c == 1) ? itfw_pkg::SPACE_CODE :
                            (c == 2) ? 8'hFF : 8'h00;
                end else begin
                    width = ($urandom_range(9) == 0) ? 8'($urandom_range(63, 33))
                                                     : 8'($urandom_range(32, 1));
                    case ($urandom_range(3))
                        0, 1: fill = itfw_pkg::SPACE_CODE;
                        2: fill = itfw_pkg::DIGIT_ZERO;
                        default: fill = 8'($urandom_range(255));
                    endcase
                end
                set_format(width, fill);
                idle_pct  = idle_tab[p];
                stall_pct = stall_tab[p];
                for (int k = 0; k < ITEMS_PER_CFG; k++) begin
                    send_value(rand_value());
                end
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        text_char_t exp_c;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    errors++;
                    $error("unexpected transaction: position %0d out_char %02h last %0b",
                           m_position, m_out_char, m_last);
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (m_position !== exp_c.position) begin
                        errors++;
                        $error("position: expected %0d actual %0d", exp_c.position, m_position);
                    end
                    if (m_out_char !== exp_c.out_char) begin
                        errors++;
                        $error("out_char: expected %02h actual %02h",
                               exp_c.out_char, m_out_char);
                    end
                    if (m_last !== exp_c.last) begin
                        errors++;
                        $error("last: expected %0b actual %0b", exp_c.last, m_last);
                    end
                end
            end
            m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_format();
        test_fill_styles();
        test_narrow_fields();
        test_width_extremes();
        test_random_traffic();
        drain_results();
        if (errors == 0) begin
            $display("int_to_fixed_width_decimal_text verification clean");
        end else begin
            $display("int_to_fixed_width_decimal_text verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/itfw_pkg.sv
sv/itfw_abs.sv
sv/itfw_dabble_stage.sv
sv/itfw_emit.sv
sv/int_to_fixed_width_decimal_text.sv
sv/itfw_checker.sv
tb/sv/int_to_fixed_width_decimal_text_test.sv
